FILE: src/min_heap_priority_queue_defines.svh
// Assertion macros shared by the checker.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the next cycle.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Assert that a condition holds in every cycle out of reset.
`define MHPQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: src/mhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;
    localparam int KEY_W = 64;
    localparam int CNT_W = 9;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP = 2'd1,
        REQ_RM_KEY = 2'd2,
        REQ_RM_VAL = 2'd3
    } t_req;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] value;
        logic [KEY_W-1:0] key;
    } t_slot;

    function automatic logic pair_less(input t_slot a, input t_slot b);
        logic ls;
        ls = ($signed(a.value) < $signed(b.value));
        if (a.key != b.key) begin
            ls = ($signed(a.key) < $signed(b.key));
        end
        return ls;
    endfunction
endpackage
`default_nettype wire

FILE: src/min_heap_priority_queue.sv
// Min-priority queue of signed (key, value) pairs held as a binary heap in one RAM.
// Input words (s_axis) carry a request: push, pop, remove by key or remove by value.
// Exactly one result word (m_axis) follows each request with the status, the
// smallest pair afterwards, the count and the empty and full flags.
// The sequencer works on one request at a time and reads or writes one RAM
// entry per cycle; one shared comparator orders pairs.
// Push sifts the new pair up the heap one level at a time; pop moves the last
// entry to the root and sifts it down. A removal scans all N entries and then
// rebuilds the heap with up to N/2 sift-downs.
// s_axis_tready is high only while the sequencer is idle and no result waits.
// A stalled receiver holds the result word in the output register and the
// block takes no new request until it is taken.
// Reset empties the queue and sets the capacity to 256; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = 256
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [8:0]   i_cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_key [63:0], entry_value [127:64]
    input  wire  [127:0] s_axis_tdata,
    // req_type [1:0]
    input  wire  [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // top_key [63:0], top_value [127:64], entry_count [136:128], is_empty [137],
    // is_full [138], zero [143:139]
    output logic [143:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]   m_axis_tuser
);
    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int PW = AW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_PU_RD, S_PU_WAIT, S_PU_CMP, S_PO_RDL, S_PO_SET, S_SD_RDL, S_SD_RDR,
        S_SD_WAIT, S_SD_CMP, S_SD_SWP, S_RM_RD, S_RM_CHK, S_RB_NEXT, S_TOP, S_TOP_W,
        S_OUT
    } t_state;

    t_slot mem [HEAP_DEPTH];
    t_slot r_rdata;
    logic [AW-1:0] r_raddr;
    logic r_re, r_we;
    logic [AW-1:0] r_waddr;
    t_slot r_wdata;

    t_state r_state;
    logic [PW-1:0] r_count, r_pos, r_best, r_scan, r_kept, r_rb;
    logic [8:0] r_cap;
    t_slot r_cur, r_bval, r_item;
    logic [1:0] r_req, r_status;
    logic r_rbuild, r_lval, r_rval;
    logic [PW:0] w_left;
    logic w_less;
    t_slot w_cmp_a, w_cmp_b;
    logic [PW:0] w_capn;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr] <= r_wdata;
        end
        if (r_re) begin
            r_rdata <= mem[r_raddr];
        end
    end

    assign w_capn = ({1'b0, r_cap} < (PW+1)'(HEAP_DEPTH)) ? (PW+1)'(r_cap)
                                                          : (PW+1)'(HEAP_DEPTH);
    assign w_left = {r_pos, 1'b1};

    always_comb begin
        w_cmp_a = r_rdata;
        w_cmp_b = r_bval;
        if (r_state == S_PU_CMP) begin
            w_cmp_a = r_cur;
            w_cmp_b = r_rdata;
        end
    end

    mhpq_cmp u_cmp (.i_a(w_cmp_a), .i_b(w_cmp_b), .o_less(w_less));

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        r_re <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap <= 9'd256;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req <= s_axis_tuser;
                        r_item <= s_axis_tdata;
                        r_cur <= s_axis_tdata;
                        r_status <= ST_DONE;
                        r_rbuild <= 1'b0;
                        unique case (t_req'(s_axis_tuser))
                            REQ_PUSH: begin
                                if ({1'b0, r_count} >= w_capn) begin
                                    r_status <= ST_FULL;
                                    r_state <= S_TOP;
                                end else begin
                                    r_pos <= r_count;
                                    r_count <= r_count + 1'b1;
                                    r_state <= S_PU_RD;
                                end
                            end
                            REQ_POP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state <= S_TOP;
                                end else begin
                                    r_count <= r_count - 1'b1;
                                    r_re <= 1'b1;
                                    r_raddr <= AW'(r_count - 1'b1);
                                    r_state <= S_PO_RDL;
                                end
                            end
                            default: begin
                                r_scan <= '0;
                                r_kept <= '0;
                                r_lval <= 1'b0;
                                r_state <= S_RM_RD;
                            end
                        endcase
                    end
                end
                S_PU_RD: begin
                    if (r_pos == '0) begin
                        r_we <= 1'b1;
                        r_waddr <= '0;
                        r_wdata <= r_cur;
                        r_state <= S_TOP;
                    end else begin
                        r_re <= 1'b1;
                        r_raddr <= AW'((r_pos - 1'b1) >> 1);
                        r_state <= S_PU_WAIT;
                    end
                end
                S_PU_WAIT: begin
                    r_state <= S_PU_CMP;
                end
                S_PU_CMP: begin
                    r_we <= 1'b1;
                    r_waddr <= AW'(r_pos);
                    if (w_less) begin
                        r_wdata <= r_rdata;
                        r_pos <= (r_pos - 1'b1) >> 1;
                        r_state <= S_PU_RD;
                    end else begin
                        r_wdata <= r_cur;
                        r_state <= S_TOP;
                    end
                end
                S_PO_RDL: begin
                    r_state <= S_PO_SET;
                end
                S_PO_SET: begin
                    r_cur <= r_rdata;
                    r_pos <= '0;
                    if (r_count == '0) begin
                        r_state <= S_TOP;
                    end else begin
                        r_state <= S_SD_RDL;
                    end
                end
                S_SD_RDL: begin
                    r_bval <= r_cur;
                    r_best <= r_pos;
                    r_lval <= w_left < {1'b0, r_count};
                    r_rval <= (w_left + 1'b1) < {1'b0, r_count};
                    if (w_left < {1'b0, r_count}) begin
                        r_re <= 1'b1;
                        r_raddr <= AW'(w_left);
                        r_state <= S_SD_RDR;
                    end else begin
                        r_state <= S_SD_SWP;
                    end
                end
                S_SD_RDR: begin
                    r_state <= S_SD_WAIT;
                end
                S_SD_WAIT: begin
                    if (w_less) begin
                        r_bval <= r_rdata;
                        r_best <= PW'(w_left);
                    end
                    if (r_rval) begin
                        r_re <= 1'b1;
                        r_raddr <= AW'(w_left + 1'b1);
                        r_state <= S_SD_CMP;
                    end else begin
                        r_state <= S_SD_SWP;
                    end
                end
                S_SD_CMP: begin
                    r_lval <= 1'b0;
                    r_state <= S_SD_CMP;
                    if (!r_lval) begin
                        if (w_less) begin
                            r_bval <= r_rdata;
                            r_best <= PW'(w_left + 1'b1);
                        end
                        r_state <= S_SD_SWP;
                    end
                end
                S_SD_SWP: begin
                    r_we <= 1'b1;
                    r_waddr <= AW'(r_pos);
                    if (r_best == r_pos) begin
                        r_wdata <= r_cur;
                        r_state <= r_rbuild ? S_RB_NEXT : S_TOP;
                    end else begin
                        r_wdata <= r_bval;
                        r_pos <= r_best;
                        r_state <= S_SD_RDL;
                    end
                end
                S_RM_RD: begin
                    if (r_scan >= r_count) begin
                        r_count <= r_kept;
                        r_rb <= r_kept >> 1;
                        r_rbuild <= 1'b1;
                        r_state <= S_RB_NEXT;
                    end else begin
                        r_re <= 1'b1;
                        r_raddr <= AW'(r_scan);
                        r_state <= S_RM_CHK;
                    end
                end
                S_RM_CHK: begin
                    r_lval <= 1'b0;
                    r_state <= S_RM_CHK;
                    if (r_lval) begin
                        r_state <= S_RM_RD;
                        r_scan <= r_scan + 1'b1;
                        if ((r_req == REQ_RM_KEY) ? (r_rdata.key != r_item.key)
                                                  : (r_rdata.value != r_item.value)) begin
                            r_we <= 1'b1;
                            r_waddr <= AW'(r_kept);
                            r_wdata <= r_rdata;
                            r_kept <= r_kept + 1'b1;
                        end
                    end else begin
                        r_lval <= 1'b1;
                    end
                end
                S_RB_NEXT: begin
                    if (r_rb == '0) begin
                        r_state <= S_TOP;
                    end else begin
                        r_rb <= r_rb - 1'b1;
                        r_pos <= r_rb - 1'b1;
                        r_re <= 1'b1;
                        r_raddr <= AW'(r_rb - 1'b1);
                        r_state <= S_PO_RDL;
                    end
                end
                S_TOP: begin
                    r_re <= 1'b1;
                    r_raddr <= '0;
                    r_state <= S_TOP_W;
                end
                S_TOP_W: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tuser <= r_status;
                    m_axis_tdata <= {5'd0,
                        ({1'b0, r_count} >= w_capn),
                        (r_count == '0),
                        9'(r_count),
                        (r_count == '0) ? 128'd0 : r_rdata};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_PO_SET && r_rbuild) begin
                r_pos <= r_pos;
                r_state <= S_SD_RDL;
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/mhpq_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  wire t_slot i_a,
    input  wire t_slot i_b,
    output logic       o_less
);
    assign o_less = pair_less(i_a, i_b);
endmodule
`default_nettype wire

FILE: src/mhpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "min_heap_priority_queue_defines.svh"
module mhpq_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [143:0] m_axis_tdata,
    input wire [1:0]   m_axis_tuser
);
    `MHPQ_ASSERT_ALWAYS(a_no_ready_with_result, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
    `MHPQ_ASSERT_ALWAYS(a_empty_count, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tdata[137] == (m_axis_tdata[136:128] == 9'd0)), "empty flag mismatch")
    `MHPQ_ASSERT_ALWAYS(a_empty_zero, i_clk, i_rst_n, !m_axis_tvalid || !m_axis_tdata[137] || (m_axis_tdata[127:0] == 128'd0), "top not zero when empty")
    `MHPQ_ASSERT_ALWAYS(a_status_known, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tuser != 2'd3), "unknown status code")
    `MHPQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")
endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

FILE: test/min_heap_priority_queue_checker.sv
`timescale 1ns / 1ps
module min_heap_priority_queue_checker
    import mhpq_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [8:0]   i_cfg_wdata,
    input  wire          i_req_valid,
    input  wire          i_req_ready,
    input  wire  [127:0] i_req_data,
    input  wire  [1:0]   i_req_user,
    input  wire          i_rsp_valid,
    input  wire          i_rsp_ready,
    input  wire  [143:0] i_rsp_data,
    input  wire  [1:0]   i_rsp_user,
    output int           o_fail_count,
    output int           o_pending
);
    localparam int DEPTH = 256;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] top_key;
        logic [63:0] top_value;
        logic [8:0]  count;
        logic        empty;
        logic        full;
    } t_outcome;

    t_slot    queue_pairs[$];
    int       capacity;
    t_outcome outcome_fifo[$];

    function automatic bit pair_before(t_slot a, t_slot b);
        if (a.key != b.key) begin
            return $signed(a.key) < $signed(b.key);
        end
        return $signed(a.value) < $signed(b.value);
    endfunction

    // The heap arrangement does not matter for the result: only the minimum,
    // which is unique up to identical pairs, is visible.
    function automatic t_outcome serve_request(t_req req, logic [63:0] key,
                                               logic [63:0] value);
        t_outcome res;
        t_slot    kept[$];
        t_slot    pair;
        int       lo;
        int       cap;
        cap = capacity < DEPTH ? capacity : DEPTH;
        res = '0;
        res.status = ST_DONE;
        pair.key = key;
        pair.value = value;
        case (req)
            REQ_PUSH: begin
                if (queue_pairs.size() >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    queue_pairs.push_back(pair);
                end
            end
            REQ_POP: begin
                if (queue_pairs.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    lo = 0;
                    foreach (queue_pairs[i]) begin
                        if (pair_before(queue_pairs[i], queue_pairs[lo])) lo = i;
                    end
                    queue_pairs.delete(lo);
                end
            end
            default: begin
                foreach (queue_pairs[i]) begin
                    if (req == REQ_RM_KEY ? queue_pairs[i].key != key
                                          : queue_pairs[i].value != value) begin
                        kept.push_back(queue_pairs[i]);
                    end
                end
                queue_pairs = kept;
            end
        endcase
        if (queue_pairs.size() > 0) begin
            lo = 0;
            foreach (queue_pairs[i]) begin
                if (pair_before(queue_pairs[i], queue_pairs[lo])) lo = i;
            end
            res.top_key = queue_pairs[lo].key;
            res.top_value = queue_pairs[lo].value;
        end
        res.count = queue_pairs.size();
        res.empty = queue_pairs.size() == 0;
        res.full = queue_pairs.size() >= cap;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            queue_pairs.delete();
            outcome_fifo.delete();
            capacity <= 256;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) capacity <= i_cfg_wdata;
            if (i_req_valid && i_req_ready) begin
                outcome_fifo.push_back(serve_request(t_req'(i_req_user),
                                                     i_req_data[63:0],
                                                     i_req_data[127:64]));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (outcome_fifo.size() == 0) begin
                    $error("unexpected result word");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = outcome_fifo.pop_front();
                    if (want.status !== i_rsp_user ||
                        want.top_key !== i_rsp_data[63:0] ||
                        want.top_value !== i_rsp_data[127:64] ||
                        want.count !== i_rsp_data[136:128] ||
                        want.empty !== i_rsp_data[137] ||
                        want.full !== i_rsp_data[138] ||
                        i_rsp_data[143:139] !== 5'd0) begin
                        o_fail_count <= o_fail_count + 1;
                        if (want.status !== i_rsp_user)
                            $error("status: expected %0d, got %0d", want.status, i_rsp_user);
                        if (want.top_key !== i_rsp_data[63:0])
                            $error("top_key: expected %0h, got %0h", want.top_key,
                                   i_rsp_data[63:0]);
                        if (want.top_value !== i_rsp_data[127:64])
                            $error("top_value: expected %0h, got %0h", want.top_value,
                                   i_rsp_data[127:64]);
                        if (want.count !== i_rsp_data[136:128])
                            $error("entry_count: expected %0d, got %0d", want.count,
                                   i_rsp_data[136:128]);
                        if (want.empty !== i_rsp_data[137])
                            $error("is_empty: expected %0b, got %0b", want.empty,
                                   i_rsp_data[137]);
                        if (want.full !== i_rsp_data[138])
                            $error("is_full: expected %0b, got %0b", want.full,
                                   i_rsp_data[138]);
                        if (i_rsp_data[143:139] !== 5'd0)
                            $error("pad: expected 0, got %0h", i_rsp_data[143:139]);
                    end
                end
            end
            o_pending <= outcome_fifo.size();
        end
    end
endmodule

FILE: test/min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
module min_heap_priority_queue_tb;
    import mhpq_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [8:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_count;
    int           pending;
    bit           calm = 1'b0;
    logic [63:0]  key_pool[8];
    logic [63:0]  value_pool[8];

    always #4 i_clk = ~i_clk;

    min_heap_priority_queue u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    min_heap_priority_queue_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata), .i_rsp_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls in bursts until the final stretch of the run.
    always begin
        int gap;
        @(posedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            m_axis_tready <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
    end

    task automatic send_request(t_req req, logic [63:0] key, logic [63:0] value);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {value, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [8:0] cap);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] wide_random();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(int items, int fill_bias);
        int pick;
        t_req req;
        logic [63:0] key;
        logic [63:0] value;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < fill_bias) req = REQ_PUSH;
            else if (pick < 92) req = REQ_POP;
            else if (pick < 96) req = REQ_RM_KEY;
            else req = REQ_RM_VAL;
            key = $urandom_range(0, 3) == 0 ? wide_random() : key_pool[$urandom_range(0, 7)];
            value = $urandom_range(0, 3) == 0 ? wide_random()
                                              : value_pool[$urandom_range(0, 7)];
            send_request(req, key, value);
        end
    endtask

    initial begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        key_pool = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd1,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 64'hFFFF_FFFF_FFFF_FFFB, 64'd100};
        value_pool = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd2,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'd7, 64'hAAAA_5555_AAAA_5555, 64'd3};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_POP, 64'd0, 64'd0);
        send_request(REQ_RM_KEY, 64'd1, 64'd0);
        send_request(REQ_PUSH, 64'd5, 64'd7);
        send_request(REQ_PUSH, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(REQ_PUSH, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_request(REQ_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_PUSH, 64'd5, 64'd7);
        send_request(REQ_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_request(REQ_RM_KEY, 64'd42, 64'd0);
        send_request(REQ_POP, 64'd0, 64'd0);
        send_request(REQ_RM_VAL, 64'd0, 64'd7);
        send_request(REQ_RM_KEY, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        send_request(REQ_POP, 64'd0, 64'd0);
        send_request(REQ_POP, 64'd0, 64'd0);
        send_request(REQ_POP, 64'd0, 64'd0);

        set_capacity(9'd0);
        send_request(REQ_PUSH, 64'd1, 64'd1);
        set_capacity(9'd3);
        for (int n = 0; n < 4; n++) send_request(REQ_PUSH, 64'(n), 64'd2);
        set_capacity(9'd1);
        send_request(REQ_POP, 64'd0, 64'd0);
        send_request(REQ_PUSH, 64'd9, 64'd9);
        set_capacity(9'h1FF);
        random_phase(250, 60);
        set_capacity(9'd256);
        random_phase(300, 75);
        set_capacity(9'd4);
        random_phase(200, 50);
        set_capacity(9'd300);
        random_phase(200, 30);
        set_capacity(9'd17);
        random_phase(200, 60);
        calm = 1'b1;
        random_phase(150, 55);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/mhpq_pkg.sv
src/mhpq_cmp.sv
src/min_heap_priority_queue.sv
src/mhpq_checker.sv
test/min_heap_priority_queue_checker.sv
test/min_heap_priority_queue_tb.sv
